FILE: rtl/core/keypad_command_frame_builder_unit_macros.svh
// assertion macros used by the checker file of the frame builder
// no dependencies; included by bare file name
`ifndef KEYPAD_COMMAND_FRAME_BUILDER_UNIT_MACROS_SVH
`define KEYPAD_COMMAND_FRAME_BUILDER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define KCFB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define KCFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/kcfb_pkg.sv
// types, codes and constants of the keypad command frame builder
// no dependencies; used by every other file of the block but the macros header
package kcfb_pkg;

	localparam int MODE_W     = 2;
	localparam int TVAL_W     = 31;
	localparam int TUNIT_W    = 3;
	localparam int BYTE_W     = 8;
	localparam int KEY_W      = 32;
	localparam int COL_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int TICK_W     = 32;
	localparam int DIGITS     = 8;
	localparam int BCD_W      = 4 * DIGITS;
	localparam int NUM_TIMING = 5;
	localparam int IDX_W      = 6;
	localparam int PROD_W     = TVAL_W + TICK_W;

	// us to 100 us ticks: multiply by ceil(2^38 / 100), keep bits 38 and up
	localparam int            RECIP_SHIFT = 38;
	localparam logic [31:0]   RECIP_100   = 32'd2748779070;

	localparam logic [5:0]    CONV_STEPS  = 6'd32;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [BYTE_W-1:0] RESET_BYTE = 8'h5F;
	localparam logic [BYTE_W-1:0] START_BYTE = 8'h23;
	localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

	localparam logic [IDX_W-1:0] EXT_LAST     = 6'd46;
	localparam logic [IDX_W-1:0] SWEEP_LAST   = 6'd37;
	localparam logic [IDX_W-1:0] TIMING_FIRST = 6'd32;
	localparam logic [IDX_W-1:0] TIMING_LAST  = 6'd36;
	localparam logic [IDX_W-1:0] NIBBLE_POS   = 6'd37;
	localparam logic [IDX_W-1:0] COLUMN_POS   = 6'd38;

	typedef enum logic [MODE_W-1:0] {
		MODE_EXT   = 2'd0,
		MODE_SWEEP = 2'd1,
		MODE_RST   = 2'd2,
		MODE_START = 2'd3
	} mode_t;

	typedef enum logic [TUNIT_W-1:0] {
		UNIT_US  = 3'd0,
		UNIT_MS  = 3'd1,
		UNIT_S   = 3'd2,
		UNIT_MIN = 3'd3,
		UNIT_H   = 3'd4
	} unit_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_MATRIX = 3'd0,
		REG_SEL_COLUMN = 3'd1,
		REG_PULSE      = 3'd2,
		REG_DELAY_A    = 3'd3,
		REG_DELAY_B    = 3'd4,
		REG_DELAY_C    = 3'd5,
		REG_DELAY_D    = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [KEY_W-1:0]                   key_matrix;
		logic [COL_W-1:0]                   selected_column;
		logic [NUM_TIMING-1:0][BYTE_W-1:0]  timing;
	} cfg_regs_t;

	// one classified request between front and back
	typedef struct packed {
		mode_t             mode;
		logic [BCD_W-1:0]  digits;
	} frame_req_t;

	typedef struct packed {
		logic        push;
		frame_req_t  req;
	} q_wr_t;

	typedef struct packed {
		logic        avail;
		frame_req_t  req;
	} q_rd_t;

	// multiplier operand for each time unit; unused codes give zero
	function automatic logic [31:0] unit_scale(input logic [TUNIT_W-1:0] unit);
		logic [31:0] s;
		case (unit)
			UNIT_US:  s = RECIP_100;
			UNIT_MS:  s = 32'd10;
			UNIT_S:   s = 32'd10000;
			UNIT_MIN: s = 32'd600000;
			UNIT_H:   s = 32'd36000000;
			default:  s = 32'd0;
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/core/kcfb_req_if.sv
// request channel of the frame builder: mode and time fields
// depends on kcfb_pkg
interface kcfb_req_if;
	logic                          valid;
	logic                          ready;
	logic [kcfb_pkg::MODE_W-1:0]   mode;
	logic [kcfb_pkg::TVAL_W-1:0]   time_value;
	logic [kcfb_pkg::TUNIT_W-1:0]  time_unit;

	modport source(output valid, mode, time_value, time_unit, input ready);
	modport sink(input valid, mode, time_value, time_unit, output ready);
endinterface

FILE: rtl/core/kcfb_rsp_if.sv
// byte channel of the frame builder: frame byte and last mark
// depends on kcfb_pkg
interface kcfb_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [kcfb_pkg::BYTE_W-1:0]  frame_byte;
	logic                         last;

	modport source(output valid, frame_byte, last, input ready);
	modport sink(input valid, frame_byte, last, output ready);
endinterface

FILE: rtl/core/kcfb_cfg_if.sv
// register write channel of the frame builder
// depends on kcfb_pkg
interface kcfb_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [kcfb_pkg::CFG_IDX_W-1:0]   index;
	logic [kcfb_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/core/kcfb_front.sv
// front end: takes requests, converts time to ticks and to eight bcd digits
// depends on kcfb_pkg and kcfb_req_if
module kcfb_front (
	input  logic             clk,
	input  logic             arst_n,
	kcfb_req_if.sink         req,
	output kcfb_pkg::q_wr_t  q_wr,
	input  logic             q_full
);
	import kcfb_pkg::*;

	logic                valid_s1;
	mode_t               mode_s1;
	logic [TICK_W-1:0]   bin_q;
	logic [BCD_W-1:0]    bcd_q;
	logic [5:0]          cnt_q;

	logic [PROD_W-1:0]   prod;
	logic [TICK_W-1:0]   ticks;
	logic [BCD_W-1:0]    bcd_adj;
	logic                conv_done;
	logic                push;
	logic                accept;

	always_comb begin
		prod = PROD_W'(req.time_value) * PROD_W'(unit_scale(req.time_unit));
		if (req.time_unit == UNIT_US) begin
			ticks = TICK_W'(prod >> RECIP_SHIFT);
		end else begin
			ticks = prod[TICK_W-1:0];
		end
		// ticks are counted in steps of eight
		ticks = {ticks[TICK_W-1:3], 3'b000};
	end

	// shift-and-add-3; the carry out of the top digit is dropped (mod 1e8)
	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) begin
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end else begin
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4];
			end
		end
	end

	assign conv_done = (mode_s1 != MODE_EXT) || (cnt_q == CONV_STEPS);
	assign push      = valid_s1 && conv_done && !q_full;
	assign req.ready = !valid_s1 || push;
	assign accept    = req.valid && req.ready;

	assign q_wr.push       = push;
	assign q_wr.req.mode   = mode_s1;
	assign q_wr.req.digits = bcd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && !conv_done) begin
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode_t'(req.mode);
			bin_q   <= ticks;
			bcd_q   <= '0;
		end else if (valid_s1 && !conv_done) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[TICK_W-1]};
			bin_q <= {bin_q[TICK_W-2:0], 1'b0};
		end
	end

endmodule

FILE: rtl/core/kcfb_queue.sv
// short queue of classified requests between front and back
// depends on kcfb_pkg
module kcfb_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  kcfb_pkg::q_wr_t  q_wr,
	output logic             q_full,
	output kcfb_pkg::q_rd_t  q_rd,
	input  logic             q_pop
);
	import kcfb_pkg::*;

	frame_req_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign q_full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign q_rd.avail = (count_q != '0);
	assign q_rd.req   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({q_wr.push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			mem_q[wr_ptr_q] <= q_wr.req;
		end
	end

endmodule

FILE: rtl/core/kcfb_back.sv
// back end: walks one frame a byte at a time into the output register
// depends on kcfb_pkg and kcfb_rsp_if
module kcfb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kcfb_pkg::q_rd_t      q_rd,
	output logic                 q_pop,
	input  kcfb_pkg::cfg_regs_t  cfg_regs,
	kcfb_rsp_if.source           rsp
);
	import kcfb_pkg::*;

	logic                cur_valid_q;
	frame_req_t          cur_q;
	logic [IDX_W-1:0]    idx_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                out_last_q;

	logic [BYTE_W-1:0]   byte_c;
	logic [IDX_W-1:0]    last_idx;
	logic                cur_last;
	logic                load;
	logic [2:0]          tsel;
	logic [2:0]          dsel;
	logic [3:0]          nibble;

	// pulse width sits in the top timing slot, delay d in the bottom one
	assign tsel   = 3'(TIMING_LAST - idx_q);
	// first digit byte takes the most significant bcd digit
	assign dsel   = 3'(EXT_LAST - idx_q);
	assign nibble = cfg_regs.key_matrix[{cfg_regs.selected_column, 2'b00} +: 4];

	always_comb begin
		byte_c   = '0;
		last_idx = '0;
		case (cur_q.mode)
			MODE_RST: begin
				byte_c = RESET_BYTE;
			end
			MODE_START: begin
				byte_c = START_BYTE;
			end
			MODE_SWEEP: begin
				last_idx = SWEEP_LAST;
				if (idx_q inside {[TIMING_FIRST:TIMING_LAST]}) begin
					byte_c = cfg_regs.timing[tsel];
				end
			end
			MODE_EXT: begin
				last_idx = EXT_LAST;
				if (idx_q < TIMING_FIRST) begin
					byte_c = BYTE_W'(cfg_regs.key_matrix[idx_q[4:0]]);
				end else if (idx_q <= TIMING_LAST) begin
					byte_c = cfg_regs.timing[tsel];
				end else if (idx_q == NIBBLE_POS) begin
					byte_c = ASCII_ZERO + BYTE_W'(nibble);
				end else if (idx_q == COLUMN_POS) begin
					byte_c = ASCII_ZERO + BYTE_W'(cfg_regs.selected_column);
				end else begin
					byte_c = ASCII_ZERO + BYTE_W'(cur_q.digits[{dsel, 2'b00} +: 4]);
				end
			end
			default: begin
				byte_c = '0;
			end
		endcase
	end

	assign cur_last = (idx_q == last_idx);
	assign load     = cur_valid_q && (!out_valid_q || rsp.ready);
	assign q_pop    = q_rd.avail && (!cur_valid_q || (load && cur_last));

	assign rsp.valid      = out_valid_q;
	assign rsp.frame_byte = out_byte_q;
	assign rsp.last       = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (load && cur_last) begin
				cur_valid_q <= 1'b0;
			end else if (load) begin
				idx_q <= idx_q + 6'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_rd.req;
		end
		if (load) begin
			out_byte_q <= byte_c;
			out_last_q <= cur_last;
		end
	end

endmodule

FILE: rtl/core/keypad_command_frame_builder_unit.sv
// Keypad command frame builder. Each request yields one frame on rsp, one byte per
// cycle while rsp.ready is high: 47 bytes for an extended frame, 38 for a reset sweep,
// a single byte for the reset and start commands. The back end emits one byte per
// clock while rsp.ready is high, so the frame length sets the rate: a frame whose
// request is already queued follows the last byte of the previous frame with no gap.
// The front end converts an extended request to decimal bit-serially, overlapped
// with the back end through a two-entry queue; it takes a new request only as it
// pushes the last one. Registers are taken on cfg at any time and read live by the
// back end, so write them only while no frame is in flight.
module keypad_command_frame_builder_unit (
	input  logic        clk,
	input  logic        arst_n,
	kcfb_req_if.sink    req,
	kcfb_rsp_if.source  rsp,
	kcfb_cfg_if.sink    cfg
);
	import kcfb_pkg::*;

	cfg_regs_t   cfg_regs_q;
	q_wr_t       q_wr;
	q_rd_t       q_rd;
	logic        q_full;
	logic        q_pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_idx_t'(cfg.index))
				REG_KEY_MATRIX: cfg_regs_q.key_matrix      <= cfg.data[KEY_W-1:0];
				REG_SEL_COLUMN: cfg_regs_q.selected_column <= cfg.data[COL_W-1:0];
				REG_PULSE:      cfg_regs_q.timing[4]       <= cfg.data[BYTE_W-1:0];
				REG_DELAY_A:    cfg_regs_q.timing[3]       <= cfg.data[BYTE_W-1:0];
				REG_DELAY_B:    cfg_regs_q.timing[2]       <= cfg.data[BYTE_W-1:0];
				REG_DELAY_C:    cfg_regs_q.timing[1]       <= cfg.data[BYTE_W-1:0];
				REG_DELAY_D:    cfg_regs_q.timing[0]       <= cfg.data[BYTE_W-1:0];
				default:        cfg_regs_q <= cfg_regs_q;
			endcase
		end
	end

	kcfb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_wr   (q_wr),
		.q_full (q_full)
	);

	kcfb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_full (q_full),
		.q_rd   (q_rd),
		.q_pop  (q_pop)
	);

	kcfb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rd     (q_rd),
		.q_pop    (q_pop),
		.cfg_regs (cfg_regs_q),
		.rsp      (rsp)
	);

endmodule

FILE: rtl/core/kcfb_checker.sv
// port-level checks on the byte stream of the frame builder, bound to the top level
// depends on kcfb_pkg and keypad_command_frame_builder_unit_macros.svh
`include "keypad_command_frame_builder_unit_macros.svh"

module kcfb_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rsp_valid,
	input  logic                         rsp_ready,
	input  logic [kcfb_pkg::BYTE_W-1:0]  rsp_frame_byte,
	input  logic                         rsp_last
);
	import kcfb_pkg::*;

	// position of the next byte within the current frame
	logic [IDX_W-1:0] pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			pos_q <= rsp_last ? '0 : pos_q + 6'd1;
		end
	end

	`KCFB_ASSERT_NEXT(a_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_last), "stalled byte changed")

	`KCFB_ASSERT_IMPLIES(a_frame_len, clk, arst_n, rsp_valid && rsp_last, pos_q == 6'd0 || pos_q == SWEEP_LAST || pos_q == EXT_LAST, "frame of illegal length")

	`KCFB_ASSERT_IMPLIES(a_ext_end, clk, arst_n, rsp_valid && pos_q == EXT_LAST, rsp_last, "frame runs past 47 bytes")

	`KCFB_ASSERT_IMPLIES(a_digits, clk, arst_n, rsp_valid && pos_q > COLUMN_POS, rsp_frame_byte >= ASCII_ZERO && rsp_frame_byte <= ASCII_NINE, "time byte not a decimal digit")

	`KCFB_ASSERT_IMPLIES(a_command, clk, arst_n, rsp_valid && rsp_last && pos_q == 6'd0, rsp_frame_byte == RESET_BYTE || rsp_frame_byte == START_BYTE, "single-byte frame is not a command")

endmodule

bind keypad_command_frame_builder_unit kcfb_checker u_kcfb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_frame_byte (rsp.frame_byte),
	.rsp_last       (rsp.last)
);
